// ----- rtl/apes_pkg.sv -----
// Package for the acceleration profile extension search block.
// Holds the command and status codes, the default table depth and the word types.
// No dependencies.
package apes_pkg;

  // Default number of profile table entries.
  localparam int DefaultProfileDepth = 256;

  // Width used to compare narrow indexes against the table depth.
  localparam int IdxExtW = 13;

  // Command codes of an input word.
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Status codes of a result word.
  localparam logic STATUS_REACHED   = 1'b0;
  localparam logic STATUS_EXHAUSTED = 1'b1;

  // One input word.
  typedef struct packed {
    logic        cmd;
    logic [7:0]  entry_index;
    logic [15:0] entry_value;
    logic [23:0] extra_distance;
    logic [8:0]  start_index;
  } apes_item_t;

  // One result word.
  typedef struct packed {
    logic        status;
    logic [9:0]  periods_needed;
    logic        count_is_odd;
    logic [15:0] remaining_in_last;
  } apes_result_t;

endpackage

// ----- rtl/apes_table.sv -----
// Profile table storage: one write port and one registered read port.
// Depends on apes_pkg for the default depth.
module apes_table
  import apes_pkg::*;
#(
  parameter int PROFILE_DEPTH = DefaultProfileDepth,
  parameter int AW = (PROFILE_DEPTH > 1) ? $clog2(PROFILE_DEPTH) : 1
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [15:0]   wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [15:0]   rd_data
);

  logic [15:0] mem [PROFILE_DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port; data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/apes_walker.sv -----
// Query sequencer: walks the profile table from the start index and builds the result word.
// Depends on apes_pkg for the word types and codes.
module apes_walker
  import apes_pkg::*;
#(
  parameter int PROFILE_DEPTH = DefaultProfileDepth,
  parameter int AW = (PROFILE_DEPTH > 1) ? $clog2(PROFILE_DEPTH) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  apes_item_t    item,
  input  logic [15:0]   rd_data,
  output logic          rd_en,
  output logic [AW-1:0] rd_addr,
  output logic          busy,
  output logic          done,
  output apes_result_t  result
);

  localparam int PW = $clog2(PROFILE_DEPTH + 1);

  typedef enum logic [1:0] {
    IDLE,
    HALF0,
    HALF1
  } state_t;

  state_t         state;
  logic [PW-1:0]  pos;
  logic [PW-1:0]  pos_next;
  logic [23:0]    sum;
  logic [24:0]    sum_next;
  logic [9:0]     count;
  logic [9:0]     count_next;
  logic [23:0]    target;
  logic           reached;
  logic           accept_query;
  logic           bad_start;
  logic [IdxExtW-1:0] start_ext;

  assign busy = (state != IDLE);
  assign accept_query = start && !busy && (item.cmd == CMD_QUERY);
  assign start_ext = IdxExtW'(item.start_index);
  assign bad_start = (start_ext >= IdxExtW'(PROFILE_DEPTH));

  // One addition of the current entry and the reach test.
  assign sum_next   = {1'b0, sum} + 25'(rd_data);
  assign count_next = count + 10'd1;
  assign reached    = (sum_next >= {1'b0, target});
  assign pos_next   = pos + PW'(1);

  // Table reads: the start entry at acceptance, the next entry in the second half.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = start_ext[AW-1:0];
    if (accept_query) begin
      rd_en = 1'b1;
    end else if (state == HALF1) begin
      rd_en   = 1'b1;
      rd_addr = pos_next[AW-1:0];
    end
  end

  // Sequencer state and the registered result word.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        IDLE: begin
          if (accept_query) begin
            sum    <= '0;
            count  <= '0;
            target <= item.extra_distance;
            pos    <= start_ext[PW-1:0];
            if (bad_start) begin
              result <= '{status: STATUS_EXHAUSTED, periods_needed: '0,
                          count_is_odd: 1'b0, remaining_in_last: '0};
              done   <= 1'b1;
            end else begin
              state <= HALF0;
            end
          end
        end
        HALF0, HALF1: begin
          if (reached) begin
            result <= '{status: STATUS_REACHED, periods_needed: count_next,
                        count_is_odd: count_next[0],
                        remaining_in_last: 16'(target - sum)};
            done   <= 1'b1;
            state  <= IDLE;
          end else begin
            sum   <= sum_next[23:0];
            count <= count_next;
            if (state == HALF0) begin
              state <= HALF1;
            end else if (pos_next == PW'(PROFILE_DEPTH)) begin
              // The table ran out before the distance was covered.
              result <= '{status: STATUS_EXHAUSTED, periods_needed: '0,
                          count_is_odd: 1'b0, remaining_in_last: '0};
              done   <= 1'b1;
              state  <= IDLE;
            end else begin
              pos   <= pos_next;
              state <= HALF0;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/accel_profile_extension_search_core.sv -----
// Acceleration profile extension search: profile table plus query sequencer.
// Depends on apes_pkg, apes_table and apes_walker.
//
// Usage:
//   A word on item is accepted at a rising edge where start is high and busy is low.
//   A load word (cmd = CMD_LOAD) writes entry_value at entry_index and gives no
//   result; indexes at or past the table depth are ignored. A load never raises
//   busy, so loads can be issued every cycle while no query walk is running.
//   A query word (cmd = CMD_QUERY) walks the table from start_index, adding every
//   entry twice. The additions of an entry fall in the states HALF0 and then HALF1,
//   as set by the single table read port and the shared adder. A query delivers
//   its result when the distance is reached or the table runs out. A start index
//   at or past the depth gives a result in the cycle after acceptance.
//   The result word is on result for exactly one cycle with done high; the
//   receiver cannot stall. busy is low in that cycle, so a new word can follow.
//   Reset clears the sequencer only; table entries are undefined until written.
module accel_profile_extension_search_core
  import apes_pkg::*;
#(
  parameter int PROFILE_DEPTH = DefaultProfileDepth
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  apes_item_t   item,
  output logic         busy,
  output logic         done,
  output apes_result_t result
);

  localparam int AW = (PROFILE_DEPTH > 1) ? $clog2(PROFILE_DEPTH) : 1;

  logic               wr_en;
  logic [IdxExtW-1:0] wr_index_ext;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic [15:0]        rd_data;

  // Load words write straight into the table.
  assign wr_index_ext = IdxExtW'(item.entry_index);
  assign wr_en = start && !busy && (item.cmd == CMD_LOAD) &&
                 (wr_index_ext < IdxExtW'(PROFILE_DEPTH));

  apes_table #(
    .PROFILE_DEPTH(PROFILE_DEPTH),
    .AW(AW)
  ) u_table (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_index_ext[AW-1:0]),
    .wr_data(item.entry_value),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  apes_walker #(
    .PROFILE_DEPTH(PROFILE_DEPTH),
    .AW(AW)
  ) u_walker (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .item   (item),
    .rd_data(rd_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  // A result is only delivered once the walk is over.
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result delivered while a walk is still running");

  // A load word never starts a walk.
  a_load_no_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.cmd == CMD_LOAD) |=> !busy)
    else $error("load word raised busy");

  // The parity flag follows the period count.
  a_odd_flag: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == STATUS_REACHED) |->
      (result.count_is_odd == result.periods_needed[0]))
    else $error("parity flag does not match period count");

  // A not-reached result carries zero fields.
  a_exhausted_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == STATUS_EXHAUSTED) |->
      (result.periods_needed == '0 && result.remaining_in_last == '0 &&
       !result.count_is_odd))
    else $error("not-reached result has nonzero fields");

endmodule

// ----- bench/accel_profile_extension_search_core_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for accel_profile_extension_search_core: directed and random
// load and query words, every result word checked against a scoreboard prediction.
// Depends on apes_pkg and the core RTL.
module accel_profile_extension_search_core_tb;
  import apes_pkg::*;

  localparam int Depth       = DefaultProfileDepth;
  localparam int ItemTarget  = 1350;
  localparam int StallLimit  = 4000;
  localparam int DrainCycles = 2 * Depth + 8;

  // Scoreboard: a private copy of the profile table and the result words still owed.
  class search_scoreboard;
    logic [15:0]  profile_copy [Depth];
    bit           entry_loaded [Depth];
    apes_result_t awaited_results [$];
    int unsigned  errors = 0;

    // Walks the table copy the way the block does. gap is the first unloaded entry the
    // walk would read, or -1 when the walk touches only loaded entries.
    function apes_result_t search_profile(input logic [23:0] target, input logic [8:0] first,
                                          output int gap);
      apes_result_t res;
      logic [25:0]  acc;
      logic [25:0]  prior;
      int unsigned  periods;
      res = '0;
      res.status = STATUS_EXHAUSTED;
      gap = -1;
      acc = '0;
      periods = 0;
      for (int p = int'(first); p < Depth; p++) begin
        if (!entry_loaded[p]) begin
          gap = p;
          return res;
        end
        // Each entry is added twice, one period per addition.
        for (int h = 0; h < 2; h++) begin
          prior = acc;
          acc = acc + profile_copy[p];
          periods++;
          if (acc >= target) begin
            res.status = STATUS_REACHED;
            res.periods_needed = periods[9:0];
            res.count_is_odd = periods[0];
            res.remaining_in_last = 16'(target - prior);
            return res;
          end
        end
      end
      return res;
    endfunction

    // Notes a word the block has accepted.
    function void note_word(apes_item_t w);
      int gap;
      if (w.cmd == CMD_LOAD) begin
        if (int'(w.entry_index) < Depth) begin
          profile_copy[w.entry_index] = w.entry_value;
          entry_loaded[w.entry_index] = 1'b1;
        end
      end else begin
        awaited_results.push_back(search_profile(w.extra_distance, w.start_index, gap));
      end
    endfunction

    // Compares a result word with the oldest prediction.
    function void check_result(apes_result_t got);
      apes_result_t want;
      if (awaited_results.size() == 0) begin
        $error("result word with no query outstanding");
        errors++;
        return;
      end
      want = awaited_results.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
      if (got.periods_needed !== want.periods_needed) begin
        $error("periods_needed: expected %0d, actual %0d",
               want.periods_needed, got.periods_needed);
        errors++;
      end
      if (got.count_is_odd !== want.count_is_odd) begin
        $error("count_is_odd: expected %0d, actual %0d", want.count_is_odd, got.count_is_odd);
        errors++;
      end
      if (got.remaining_in_last !== want.remaining_in_last) begin
        $error("remaining_in_last: expected %0d, actual %0d",
               want.remaining_in_last, got.remaining_in_last);
        errors++;
      end
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst;
  logic         start;
  apes_item_t   item;
  logic         busy;
  logic         done;
  apes_result_t result;

  search_scoreboard sb;
  int unsigned      sent = 0;
  int unsigned      stall_cycles = 0;

  accel_profile_extension_search_core #(
    .PROFILE_DEPTH(Depth)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .item(item),
    .busy(busy),
    .done(done),
    .result(result)
  );

  // 12 ns clock.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Result words are taken in the cycle they are strobed.
  always @(posedge clk) begin
    if (!rst && done) sb.check_result(result);
  end

  // Watchdog on cycles in which no word moves in either direction.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles == StallLimit) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Entry values lean toward the extremes and small steps.
  function automatic logic [15:0] rand_entry();
    case ($urandom_range(9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2, 3:    return 16'($urandom_range(255));
      default: return 16'($urandom);
    endcase
  endfunction

  // Offers one word, after random idle cycles in the idling phases, and holds start
  // until the word is accepted. start is left high for the next word.
  task automatic send_word(input apes_item_t w);
    int idle_pct;
    idle_pct = (sent < 450) ? 37 : (sent < 900) ? 48 : 0;
    // Each cycle before the word is offered is idle with the phase's probability.
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    item <= w;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    sb.note_word(w);
    sent++;
  endtask

  // Load word; the query fields carry noise.
  task automatic send_load(input logic [7:0] idx, input logic [15:0] value);
    apes_item_t w;
    w.cmd = CMD_LOAD;
    w.entry_index = idx;
    w.entry_value = value;
    w.extra_distance = 24'($urandom);
    w.start_index = 9'($urandom);
    send_word(w);
  endtask

  // Query word. Any entry the walk would read that was never loaded is loaded first.
  task automatic send_query(input logic [23:0] target, input logic [8:0] first);
    apes_item_t   w;
    apes_result_t unused;
    int           gap;
    unused = sb.search_profile(target, first, gap);
    while (gap >= 0) begin
      send_load(8'(gap), rand_entry());
      unused = sb.search_profile(target, first, gap);
    end
    w.cmd = CMD_QUERY;
    w.entry_index = 8'($urandom);
    w.entry_value = 16'($urandom);
    w.extra_distance = target;
    w.start_index = first;
    send_word(w);
  endtask

  initial begin
    int          sel;
    int          first;
    int          span;
    logic [25:0] base;
    logic [25:0] reach;

    sb = new;
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: extreme entries, zero distance, first and second addition of an entry,
    // exhaustion, bad start indexes.
    send_load(8'd0, 16'hFFFF);
    send_load(8'd255, 16'h0000);
    send_load(8'd254, 16'hFFFF);
    send_query(24'd0, 9'd255);
    send_query(24'd1, 9'd255);
    send_query(24'hFFFFFF, 9'd254);
    send_query(24'd65535, 9'd254);
    send_query(24'd65536, 9'd254);
    send_query(24'($urandom), 9'd256);
    send_query(24'hFFFFFF, 9'd511);
    send_load(8'd255, 16'h0001);
    send_query(24'h020000, 9'd254);
    send_query(24'h00FFFF, 9'd0);
    send_query(24'd0, 9'd0);

    // Random: loads, queries aimed at a chosen entry, bad starts, tiny and oversized
    // distances.
    while (sent < ItemTarget) begin
      sel = $urandom_range(99);
      if (sel < 40) begin
        send_load(8'($urandom), rand_entry());
      end else if (sel < 47) begin
        send_query(24'($urandom), 9'($urandom_range(511, 256)));
      end else if (sel < 53) begin
        send_query(24'($urandom_range(3)), 9'($urandom_range(Depth - 1)));
      end else if (sel < 60) begin
        first = ($urandom_range(1) == 0) ? $urandom_range(Depth - 1, Depth - 16)
                                         : $urandom_range(Depth - 1);
        send_query(($urandom_range(3) == 0) ? 24'hFFFFFF : 24'($urandom), 9'(first));
      end else begin
        // Pick the entry where the walk should stop and size the distance to land there.
        first = ($urandom_range(3) == 0) ? $urandom_range(7) : $urandom_range(Depth - 1);
        span = $urandom_range(Depth - first, 1);
        base = '0;
        for (int p = first; p < first + span; p++) begin
          if (!sb.entry_loaded[p]) send_load(8'(p), rand_entry());
          if (p < first + span - 1) base = base + 26'(2 * sb.profile_copy[p]);
        end
        reach = base + 26'($urandom_range(2 * sb.profile_copy[first + span - 1]));
        send_query((reach > 26'hFFFFFF) ? 24'hFFFFFF : 24'(reach), 9'(first));
      end
    end
    start <= 1'b0;

    // Wait for every owed result, then long enough for a stray one to show up.
    while (sb.awaited_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (sb.errors == 0 && sb.awaited_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
